// File: rtl/shpx_pkg.sv
// ---------------------------------------------------------------------------
// shpx_pkg
// shared types and codes for the shape proximity hit test block
// ---------------------------------------------------------------------------
`default_nettype none

package shpx_pkg;

   // quotient bits of the projection divide
   localparam int QUO_W = 17;

   // shape kind codes; both upper codes are polygons
   localparam logic [1:0] KIND_POINT = 2'd0;

   // datapath operation codes
   localparam logic [4:0] OP_NONE     = 5'd0;
   localparam logic [4:0] OP_LATCH    = 5'd1;
   localparam logic [4:0] OP_LOAD_SRC = 5'd2;
   localparam logic [4:0] OP_ADV      = 5'd3;
   localparam logic [4:0] OP_C1A      = 5'd4;
   localparam logic [4:0] OP_C1B      = 5'd5;
   localparam logic [4:0] OP_C2A      = 5'd6;
   localparam logic [4:0] OP_C2B      = 5'd7;
   localparam logic [4:0] OP_C2S      = 5'd8;
   localparam logic [4:0] OP_PT_P0    = 5'd9;
   localparam logic [4:0] OP_PT_P1    = 5'd10;
   localparam logic [4:0] OP_MH       = 5'd11;
   localparam logic [4:0] OP_ML       = 5'd12;
   localparam logic [4:0] OP_DSTEP    = 5'd13;
   localparam logic [4:0] OP_PJ       = 5'd14;
   localparam logic [4:0] OP_D1       = 5'd15;
   localparam logic [4:0] OP_D2       = 5'd16;
   localparam logic [4:0] OP_D3       = 5'd17;
   localparam logic [4:0] OP_X1       = 5'd18;
   localparam logic [4:0] OP_X2       = 5'd19;
   localparam logic [4:0] OP_RESP     = 5'd20;

   // operand pair sources: first point, second point
   localparam logic [1:0] SRC_PV = 2'd0; // prior, vertex
   localparam logic [1:0] SRC_VP = 2'd1; // vertex, prior
   localparam logic [1:0] SRC_SP = 2'd2; // start, prior

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] src;
      logic       axis;
      logic       first;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       fin;
      logic       c1_le0;
      logic       c2_le_c1;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/shpx_dp.sv
// ---------------------------------------------------------------------------
// shpx_dp
// datapath: held shape state, shared multiplier, bit-serial divider
// ---------------------------------------------------------------------------
`default_nettype none

module shpx_dp (
   input  wire                   clock,
   input  wire  [1:0]            req_kind,
   input  wire  signed [15:0]    req_query_x,
   input  wire  signed [15:0]    req_query_y,
   input  wire  [14:0]           req_radius,
   input  wire  signed [15:0]    req_vertex_x,
   input  wire  signed [15:0]    req_vertex_y,
   input  wire                   req_final_vertex,
   input  shpx_pkg::cmd_type     cmd,
   output shpx_pkg::stat_type    stat,
   output logic                  rsp_hit,
   output logic                  rsp_inside_res
);

   function automatic logic signed [17:0] sx18(input logic signed [16:0] v);
      return {v[16], v};
   endfunction

   function automatic logic is_sent(input logic signed [15:0] c);
      return (c == 16'sh7fff) || (c == 16'sh8000);
   endfunction

   logic [1:0]          kind_ff, kind_in;
   logic signed [15:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic [14:0]         rad_ff, rad_in;
   logic signed [15:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic signed [15:0]  px_ff, px_in, py_ff, py_in;
   logic signed [15:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic                fin_ff, fin_in;
   logic                parity_ff, parity_in, near_ff, near_in;
   logic signed [15:0]  ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [15:0]  ptx_ff, ptx_in, pty_ff, pty_in;
   logic signed [35:0]  acc_ff, acc_in;
   logic signed [34:0]  c1_ff, c1_in;
   logic [33:0]         c2_ff, c2_in;
   logic [49:0]         rem_ff, rem_in, dvs_ff, dvs_in;
   logic [16:0]         quo_ff, quo_in;
   logic                hit_ff, hit_in, inside_ff, inside_in;

   logic signed [16:0]  vdx, vdy, wx, wy, dx, dy, v_ax;
   logic [16:0]         v_abs;
   logic signed [17:0]  tm, ma, mb, sq, base, pj_sum;
   logic signed [35:0]  prod;
   logic                span, d_pos, use_t1, cross_hit, sent, rem_ge;
   logic [49:0]         rem_sub;

   assign vdx = {bx_ff[15], bx_ff} - {ax_ff[15], ax_ff};
   assign vdy = {by_ff[15], by_ff} - {ay_ff[15], ay_ff};
   assign wx  = {qx_ff[15], qx_ff} - {ax_ff[15], ax_ff};
   assign wy  = {qy_ff[15], qy_ff} - {ay_ff[15], ay_ff};
   assign dx  = {qx_ff[15], qx_ff} - {ptx_ff[15], ptx_ff};
   assign dy  = {qy_ff[15], qy_ff} - {pty_ff[15], pty_ff};

   assign v_ax  = cmd.axis ? vdy : vdx;
   assign v_abs = v_ax[16] ? 17'(-v_ax) : 17'(v_ax);

   // crossing test: edge from first operand to second
   assign span = ((ay_ff <= qy_ff) && (qy_ff < by_ff)) ||
                 ((by_ff <= qy_ff) && (qy_ff < ay_ff));
   assign d_pos  = !vdy[16];
   assign use_t1 = d_pos ? (acc_ff >= 36'sd0) : (acc_ff <= 36'sd0);
   assign tm     = use_t1 ? (sx18(wx) + 18'sd1) : sx18(wx);

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (cmd.op)
         shpx_pkg::OP_C1A: begin ma = sx18(vdx); mb = sx18(wx); end
         shpx_pkg::OP_C1B: begin ma = sx18(vdy); mb = sx18(wy); end
         shpx_pkg::OP_C2A: begin ma = sx18(vdx); mb = sx18(vdx); end
         shpx_pkg::OP_C2B: begin ma = sx18(vdy); mb = sx18(vdy); end
         shpx_pkg::OP_MH: begin
            ma = $signed({1'b0, v_abs});
            mb = $signed({1'b0, c1_ff[33:17]});
         end
         shpx_pkg::OP_ML: begin
            ma = $signed({1'b0, v_abs});
            mb = $signed({1'b0, c1_ff[16:0]});
         end
         shpx_pkg::OP_D1: begin ma = sx18(dx); mb = sx18(dx); end
         shpx_pkg::OP_D2: begin ma = sx18(dy); mb = sx18(dy); end
         shpx_pkg::OP_D3: begin
            ma = $signed({3'b000, rad_ff});
            mb = $signed({3'b000, rad_ff});
         end
         shpx_pkg::OP_X1: begin ma = sx18(vdx); mb = sx18(wy); end
         shpx_pkg::OP_X2: begin ma = tm; mb = sx18(vdy); end
         default: ;
      endcase
   end

   assign prod = ma * mb;

   assign cross_hit = d_pos ?
      ((acc_ff >= 36'sd0) ? (acc_ff >= prod) : (acc_ff > prod)) :
      ((acc_ff <= 36'sd0) ? (acc_ff <= prod) : (acc_ff < prod));

   assign sent = is_sent(qx_ff) || is_sent(qy_ff) || is_sent(ptx_ff) || is_sent(pty_ff);

   assign rem_ge  = rem_ff >= dvs_ff;
   assign rem_sub = rem_ff - dvs_ff;

   assign sq     = v_ax[16] ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign base   = cmd.axis ? {ay_ff[15], ay_ff[15], ay_ff} : {ax_ff[15], ax_ff[15], ax_ff};
   assign pj_sum = base + sq;

   always_comb begin
      kind_in = kind_ff;   qx_in = qx_ff;   qy_in = qy_ff;   rad_in = rad_ff;
      sx_in = sx_ff;       sy_in = sy_ff;   px_in = px_ff;   py_in = py_ff;
      vx_in = vx_ff;       vy_in = vy_ff;   fin_in = fin_ff;
      parity_in = parity_ff;  near_in = near_ff;
      ax_in = ax_ff;  ay_in = ay_ff;  bx_in = bx_ff;  by_in = by_ff;
      ptx_in = ptx_ff;  pty_in = pty_ff;
      acc_in = acc_ff;  c1_in = c1_ff;  c2_in = c2_ff;
      rem_in = rem_ff;  dvs_in = dvs_ff;  quo_in = quo_ff;
      hit_in = hit_ff;  inside_in = inside_ff;
      unique case (cmd.op)
         shpx_pkg::OP_LATCH: begin
            vx_in  = req_vertex_x;
            vy_in  = req_vertex_y;
            fin_in = req_final_vertex;
            if (cmd.first) begin
               kind_in   = req_kind;
               qx_in     = req_query_x;
               qy_in     = req_query_y;
               rad_in    = req_radius;
               sx_in     = req_vertex_x;
               sy_in     = req_vertex_y;
               px_in     = req_vertex_x;
               py_in     = req_vertex_y;
               parity_in = 1'b0;
               near_in   = 1'b0;
            end
         end
         shpx_pkg::OP_LOAD_SRC: begin
            unique case (cmd.src)
               shpx_pkg::SRC_PV: begin
                  ax_in = px_ff; ay_in = py_ff; bx_in = vx_ff; by_in = vy_ff;
               end
               shpx_pkg::SRC_VP: begin
                  ax_in = vx_ff; ay_in = vy_ff; bx_in = px_ff; by_in = py_ff;
               end
               default: begin
                  ax_in = sx_ff; ay_in = sy_ff; bx_in = px_ff; by_in = py_ff;
               end
            endcase
         end
         shpx_pkg::OP_ADV: begin
            px_in = vx_ff;
            py_in = vy_ff;
         end
         shpx_pkg::OP_C1A: acc_in = prod;
         shpx_pkg::OP_C1B: acc_in = acc_ff + prod;
         shpx_pkg::OP_C2A: begin
            c1_in  = acc_ff[34:0];
            acc_in = prod;
         end
         shpx_pkg::OP_C2B: acc_in = acc_ff + prod;
         shpx_pkg::OP_C2S: c2_in = acc_ff[33:0];
         shpx_pkg::OP_PT_P0: begin ptx_in = ax_ff; pty_in = ay_ff; end
         shpx_pkg::OP_PT_P1: begin ptx_in = bx_ff; pty_in = by_ff; end
         shpx_pkg::OP_MH: acc_in = prod;
         shpx_pkg::OP_ML: begin
            rem_in = {acc_ff[32:0], 17'b0} + {16'b0, prod[33:0]};
            dvs_in = {c2_ff, 16'b0};
            quo_in = '0;
         end
         shpx_pkg::OP_DSTEP: begin
            if (rem_ge) begin
               rem_in = rem_sub;
            end
            quo_in = {quo_ff[15:0], rem_ge};
            dvs_in = {1'b0, dvs_ff[49:1]};
         end
         shpx_pkg::OP_PJ: begin
            if (cmd.axis) begin
               pty_in = pj_sum[15:0];
            end else begin
               ptx_in = pj_sum[15:0];
            end
         end
         shpx_pkg::OP_D1: acc_in = prod;
         shpx_pkg::OP_D2: acc_in = acc_ff + prod;
         shpx_pkg::OP_D3: near_in = near_ff | (!sent && (acc_ff <= prod));
         shpx_pkg::OP_X1: acc_in = prod;
         shpx_pkg::OP_X2: parity_in = parity_ff ^ (span & cross_hit);
         shpx_pkg::OP_RESP: begin
            hit_in    = kind_ff[1] ? (parity_ff | near_ff) : near_ff;
            inside_in = kind_ff[1] & parity_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;   qx_ff <= qx_in;   qy_ff <= qy_in;   rad_ff <= rad_in;
      sx_ff <= sx_in;       sy_ff <= sy_in;   px_ff <= px_in;   py_ff <= py_in;
      vx_ff <= vx_in;       vy_ff <= vy_in;   fin_ff <= fin_in;
      parity_ff <= parity_in;  near_ff <= near_in;
      ax_ff <= ax_in;  ay_ff <= ay_in;  bx_ff <= bx_in;  by_ff <= by_in;
      ptx_ff <= ptx_in;  pty_ff <= pty_in;
      acc_ff <= acc_in;  c1_ff <= c1_in;  c2_ff <= c2_in;
      rem_ff <= rem_in;  dvs_ff <= dvs_in;  quo_ff <= quo_in;
      hit_ff <= hit_in;  inside_ff <= inside_in;
   end

   assign stat.kind     = kind_ff;
   assign stat.fin      = fin_ff;
   assign stat.c1_le0   = c1_ff <= 35'sd0;
   assign stat.c2_le_c1 = $signed({1'b0, c2_ff}) <= c1_ff;

   assign rsp_hit        = hit_ff;
   assign rsp_inside_res = inside_ff;

endmodule

`default_nettype wire

// File: rtl/shpx_ctrl.sv
// ---------------------------------------------------------------------------
// shpx_ctrl
// controller: walks the per-vertex job list and sequences datapath ops
// ---------------------------------------------------------------------------
`default_nettype none

module shpx_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   input  shpx_pkg::stat_type  stat,
   output shpx_pkg::cmd_type   cmd
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_NEXT = 5'd1;
   localparam logic [4:0] S_SEG1 = 5'd2;
   localparam logic [4:0] S_SEG2 = 5'd3;
   localparam logic [4:0] S_SEG3 = 5'd4;
   localparam logic [4:0] S_SEG4 = 5'd5;
   localparam logic [4:0] S_SEG5 = 5'd6;
   localparam logic [4:0] S_SEGD = 5'd7;
   localparam logic [4:0] S_PMH  = 5'd8;
   localparam logic [4:0] S_PML  = 5'd9;
   localparam logic [4:0] S_PDIV = 5'd10;
   localparam logic [4:0] S_PPJ  = 5'd11;
   localparam logic [4:0] S_PTL  = 5'd12;
   localparam logic [4:0] S_PT1  = 5'd13;
   localparam logic [4:0] S_PT2  = 5'd14;
   localparam logic [4:0] S_PT3  = 5'd15;
   localparam logic [4:0] S_X1   = 5'd16;
   localparam logic [4:0] S_X2   = 5'd17;
   localparam logic [4:0] S_OUT  = 5'd18;

   // per-vertex jobs, in order
   localparam logic [2:0] J_PT0    = 3'd0;
   localparam logic [2:0] J_SEG_PV = 3'd1;
   localparam logic [2:0] J_CRS_VP = 3'd2;
   localparam logic [2:0] J_ADV    = 3'd3;
   localparam logic [2:0] J_CRS_SP = 3'd4;
   localparam logic [2:0] J_SEG_SP = 3'd5;
   localparam logic [2:0] J_OUT    = 3'd6;

   logic [4:0] state_ff, state_in;
   logic [2:0] job_ff, job_in;
   logic       was_start_ff, was_start_in;
   logic       at_start_ff, at_start_in;
   logic       axis_ff, axis_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] op;
   logic [1:0] src;
   logic       poly, fin_poly;

   assign poly     = stat.kind[1];
   assign fin_poly = stat.fin & poly;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      was_start_in = was_start_ff;
      at_start_in  = at_start_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      op           = shpx_pkg::OP_NONE;
      src          = shpx_pkg::SRC_PV;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op           = shpx_pkg::OP_LATCH;
               was_start_in = at_start_ff;
               at_start_in  = 1'b0;
               job_in       = J_PT0;
               state_in     = S_NEXT;
            end
         end
         S_NEXT: begin
            job_in = job_ff + 3'd1;
            unique case (job_ff)
               J_PT0: begin
                  if (was_start_ff && (stat.kind == shpx_pkg::KIND_POINT)) begin
                     op = shpx_pkg::OP_LOAD_SRC; src = shpx_pkg::SRC_PV;
                     state_in = S_PTL;
                  end
               end
               J_SEG_PV: begin
                  if (!was_start_ff && (stat.kind != shpx_pkg::KIND_POINT)) begin
                     op = shpx_pkg::OP_LOAD_SRC; src = shpx_pkg::SRC_PV;
                     state_in = S_SEG1;
                  end
               end
               J_CRS_VP: begin
                  if (!was_start_ff && poly) begin
                     op = shpx_pkg::OP_LOAD_SRC; src = shpx_pkg::SRC_VP;
                     state_in = S_X1;
                  end
               end
               J_ADV: begin
                  if (!was_start_ff) begin
                     op = shpx_pkg::OP_ADV;
                  end
               end
               J_CRS_SP: begin
                  if (fin_poly) begin
                     op = shpx_pkg::OP_LOAD_SRC; src = shpx_pkg::SRC_SP;
                     state_in = S_X1;
                  end
               end
               J_SEG_SP: begin
                  if (fin_poly) begin
                     op = shpx_pkg::OP_LOAD_SRC; src = shpx_pkg::SRC_SP;
                     state_in = S_SEG1;
                  end
               end
               J_OUT: begin
                  if (stat.fin) begin
                     at_start_in = 1'b1;
                     state_in    = S_OUT;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SEG1: begin op = shpx_pkg::OP_C1A; state_in = S_SEG2; end
         S_SEG2: begin op = shpx_pkg::OP_C1B; state_in = S_SEG3; end
         S_SEG3: begin op = shpx_pkg::OP_C2A; state_in = S_SEG4; end
         S_SEG4: begin op = shpx_pkg::OP_C2B; state_in = S_SEG5; end
         S_SEG5: begin op = shpx_pkg::OP_C2S; state_in = S_SEGD; end
         S_SEGD: begin
            if (stat.c1_le0) begin
               op = shpx_pkg::OP_PT_P0; state_in = S_PT1;
            end else if (stat.c2_le_c1) begin
               op = shpx_pkg::OP_PT_P1; state_in = S_PT1;
            end else begin
               axis_in  = 1'b0;
               state_in = S_PMH;
            end
         end
         S_PMH: begin op = shpx_pkg::OP_MH; state_in = S_PML; end
         S_PML: begin
            op       = shpx_pkg::OP_ML;
            cnt_in   = '0;
            state_in = S_PDIV;
         end
         S_PDIV: begin
            op     = shpx_pkg::OP_DSTEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(shpx_pkg::QUO_W - 1)) begin
               state_in = S_PPJ;
            end
         end
         S_PPJ: begin
            op = shpx_pkg::OP_PJ;
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = S_PMH;
            end else begin
               state_in = S_PT1;
            end
         end
         S_PTL: begin op = shpx_pkg::OP_PT_P0; state_in = S_PT1; end
         S_PT1: begin op = shpx_pkg::OP_D1; state_in = S_PT2; end
         S_PT2: begin op = shpx_pkg::OP_D2; state_in = S_PT3; end
         S_PT3: begin op = shpx_pkg::OP_D3; state_in = S_NEXT; end
         S_X1:  begin op = shpx_pkg::OP_X1; state_in = S_X2; end
         S_X2:  begin op = shpx_pkg::OP_X2; state_in = S_NEXT; end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op           = shpx_pkg::OP_RESP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= J_PT0;
         was_start_ff <= 1'b0;
         at_start_ff  <= 1'b1;
         axis_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         was_start_ff <= was_start_in;
         at_start_ff  <= at_start_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cmd.op    = op;
   assign cmd.src   = src;
   assign cmd.axis  = axis_ff;
   assign cmd.first = at_start_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/shape_proximity_hit_test_top.sv
// a vertex holds the input until it has been processed and the next one is taken;
//   a final vertex is held from acceptance until its result transaction is offered
// throughput: one vertex at a time; a projected segment is paced by
//   the shared 18x18 multiplier and the one-bit-per-cycle 17-step divider
// reset: synchronous; controller idles expecting a first vertex, no result pending
// ---------------------------------------------------------------------------
// shape_proximity_hit_test_top
// tests whether a query point lies within a radius of a point, polyline or
// polygon whose vertices arrive one transaction at a time
// ---------------------------------------------------------------------------
`default_nettype none

module shape_proximity_hit_test_top (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire  [1:0]          req_kind,
   input  wire  signed [15:0]  req_query_x,
   input  wire  signed [15:0]  req_query_y,
   input  wire  [14:0]         req_radius,
   input  wire  signed [15:0]  req_vertex_x,
   input  wire  signed [15:0]  req_vertex_y,
   input  wire                 req_final_vertex,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic                rsp_hit,
   output logic                rsp_inside_res
);

   // command from controller, status back from datapath
   shpx_pkg::cmd_type  cmd;
   shpx_pkg::stat_type stat;

   // controller: job list per vertex (first point, segment, crossings,
   // closing edge), sub-sequences for each test, result register handshake
   shpx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: held query and vertices, one multiplier with accumulator,
   // restoring divider for the segment projection, result payload register
   shpx_dp u_dp (
      .clock            (clock),
      .req_kind         (req_kind),
      .req_query_x      (req_query_x),
      .req_query_y      (req_query_y),
      .req_radius       (req_radius),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_final_vertex (req_final_vertex),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_hit          (rsp_hit),
      .rsp_inside_res   (rsp_inside_res)
   );

endmodule

`default_nettype wire

// File: rtl/shpx_checker.sv
// ---------------------------------------------------------------------------
// shpx_checker
// port-level checks on the result channel of the hit test block
// ---------------------------------------------------------------------------
`default_nettype none

module shpx_checker (
   input wire clock,
   input wire reset,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire rsp_hit,
   input wire rsp_inside_res
);

   // a pending result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before acceptance");

   // stalled payload holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_inside_res))
      else $error("result payload changed while stalled");

   // inside a polygon always counts as a hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_inside_res || rsp_hit))
      else $error("inside without hit");

   // nothing offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind shape_proximity_hit_test_top shpx_checker u_shpx_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hit        (rsp_hit),
   .rsp_inside_res (rsp_inside_res)
);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Checks the shape proximity hit test block. Shapes (point, polyline,
// polygon) are sent vertex by vertex with random idling on both channels.
// An in-bench model predicts hit and inside for each final vertex, and each
// result transaction is compared against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

   // shape kind codes
   localparam logic [1:0] KIND_POINT    = 2'd0;
   localparam logic [1:0] KIND_POLYLINE = 2'd1;
   localparam logic [1:0] KIND_POLYGON  = 2'd2;
   localparam logic [1:0] KIND_ALIAS    = 2'd3; // behaves as polygon

   // coordinates that make a distance test fail
   localparam longint SENT_HI = 32767;
   localparam longint SENT_LO = -32768;

   localparam int IDLE_PCT     = 18;
   localparam int RANDOM_ITEMS = 1800;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 150;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_kind;
   logic signed [15:0] req_query_x;
   logic signed [15:0] req_query_y;
   logic [14:0]        req_radius;
   logic signed [15:0] req_vertex_x;
   logic signed [15:0] req_vertex_y;
   logic               req_final_vertex;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_hit;
   logic               rsp_inside_res;

   typedef struct {
      logic hit;
      logic in_poly;
   } verdict_type;

   verdict_type pending_verdicts[$];
   int       error_count = 0;
   int       quiet_cycles = 0;
   bit       calm = 0;

   // shape tracking state of the in-bench model
   bit     shape_open;
   logic [1:0] shape_kind;
   longint qx_held, qy_held, radius_held;
   longint first_x, first_y, last_x, last_y;
   bit     crossing_parity, near_found;

   shape_proximity_hit_test_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_query_x(req_query_x),
      .req_query_y(req_query_y),
      .req_radius(req_radius),
      .req_vertex_x(req_vertex_x),
      .req_vertex_y(req_vertex_y),
      .req_final_vertex(req_final_vertex),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit),
      .rsp_inside_res(rsp_inside_res)
   );

   // clock, period 2 ns
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // proximity model
   // ---------------------------------------------------------------------
   function automatic bit is_sentinel(longint c);
      return c == SENT_HI || c == SENT_LO;
   endfunction

   function automatic bit within_radius(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      if (is_sentinel(ax) || is_sentinel(ay) || is_sentinel(bx) || is_sentinel(by))
         return 0;
      dx = ax - bx;
      dy = ay - by;
      return dx * dx + dy * dy <= radius_held * radius_held;
   endfunction

   // distance from the query to segment (x0,y0)-(x1,y1), projection truncated toward zero
   function automatic bit segment_close(longint x0, longint y0, longint x1, longint y1);
      longint vx, vy, c1, c2;
      vx = x1 - x0;
      vy = y1 - y0;
      c1 = vx * (qx_held - x0) + vy * (qy_held - y0);
      if (c1 <= 0)
         return within_radius(qx_held, qy_held, x0, y0);
      c2 = vx * vx + vy * vy;
      if (c2 <= c1)
         return within_radius(qx_held, qy_held, x1, y1);
      return within_radius(qx_held, qy_held, x0 + vx * c1 / c2, y0 + vy * c1 / c2);
   endfunction

   // crossing test of the edge (xi,yi)-(xj,yj) against a ray from the query
   function automatic bit edge_crossed(longint xi, longint yi, longint xj, longint yj);
      bit span;
      span = ((yi <= qy_held) && (qy_held < yj)) || ((yj <= qy_held) && (qy_held < yi));
      if (!span)
         return 0;
      return qx_held < (xj - xi) * (qy_held - yi) / (yj - yi) + xi;
   endfunction

   function automatic void clear_shape();
      shape_open = 0;
      shape_kind = KIND_POINT;
      qx_held = 0; qy_held = 0; radius_held = 0;
      first_x = 0; first_y = 0; last_x = 0; last_y = 0;
      crossing_parity = 0;
      near_found = 0;
   endfunction

   // advance the model by one accepted vertex, queue a verdict on the final one
   function automatic void advance_shape();
      longint vx, vy;
      bit     poly;
      verdict_type v;
      vx = longint'(req_vertex_x);
      vy = longint'(req_vertex_y);
      if (!shape_open) begin
         shape_kind  = req_kind;
         qx_held     = longint'(req_query_x);
         qy_held     = longint'(req_query_y);
         radius_held = longint'({1'b0, req_radius});
         first_x = vx; first_y = vy;
         last_x  = vx; last_y  = vy;
         crossing_parity = 0;
         near_found = 0;
         if (shape_kind == KIND_POINT)
            near_found = within_radius(qx_held, qy_held, vx, vy);
         shape_open = 1;
      end else begin
         poly = shape_kind == KIND_POLYGON || shape_kind == KIND_ALIAS;
         if ((shape_kind == KIND_POLYLINE || poly) && segment_close(last_x, last_y, vx, vy))
            near_found = 1;
         if (poly && edge_crossed(vx, vy, last_x, last_y))
            crossing_parity = !crossing_parity;
         last_x = vx;
         last_y = vy;
      end
      if (!req_final_vertex)
         return;
      if (shape_kind == KIND_POLYGON || shape_kind == KIND_ALIAS) begin
         // closing edge from the first vertex back to the last
         if (edge_crossed(first_x, first_y, last_x, last_y))
            crossing_parity = !crossing_parity;
         if (segment_close(first_x, first_y, last_x, last_y))
            near_found = 1;
         v.hit     = crossing_parity || near_found;
         v.in_poly = crossing_parity;
      end else begin
         v.hit     = near_found;
         v.in_poly = 0;
      end
      pending_verdicts.push_back(v);
      shape_open = 0;
   endfunction

   // ---------------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------------

   // alternate between stretches with random idling and shorter calm stretches
   initial begin
      forever begin
         calm = 0;
         repeat (4000) @(posedge clock);
         calm = 1;
         repeat (1500) @(posedge clock);
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // send one vertex transaction and feed the model when it is accepted
   task automatic send_vertex(logic [1:0] kind, longint qx, longint qy, longint rad,
                              longint vx, longint vy, bit last);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid        <= 1;
      req_kind         <= kind;
      req_query_x      <= 16'(qx);
      req_query_y      <= 16'(qy);
      req_radius       <= 15'(rad);
      req_vertex_x     <= 16'(vx);
      req_vertex_y     <= 16'(vy);
      req_final_vertex <= last;
      do @(posedge clock); while (!req_ready);
      advance_shape();
   endtask

   // whole shape with the query latched from the first vertex
   task automatic send_shape(logic [1:0] kind, longint qx, longint qy, longint rad,
                             longint xs[$], longint ys[$]);
      for (int i = 0; i < xs.size(); i++)
         send_vertex(kind, qx, qy, rad, xs[i], ys[i], i == xs.size() - 1);
   endtask

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type v;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: result transaction with none expected, hit %0b inside %0b",
                        $time, rsp_hit, rsp_inside_res);
               error_count++;
            end else begin
               v = pending_verdicts.pop_front();
               if (rsp_hit !== v.hit) begin
                  $display("%0t: hit expected %0b actual %0b", $time, v.hit, rsp_hit);
                  error_count++;
               end
               if (rsp_inside_res !== v.in_poly) begin
                  $display("%0t: inside_res expected %0b actual %0b",
                           $time, v.in_poly, rsp_inside_res);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog on a run that stops moving
   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // point kind: exact hit, zero radius, sentinels, extra vertices ignored
   task automatic test_point_kind();
      send_shape(KIND_POINT, 5, 5, 0, '{5}, '{5});
      send_shape(KIND_POINT, 0, 0, 32767, '{-32767}, '{32766});
      send_shape(KIND_POINT, SENT_HI, 0, 32767, '{0}, '{0});
      send_shape(KIND_POINT, 0, 0, 32767, '{SENT_LO}, '{0});
      send_shape(KIND_POINT, 100, 100, 10, '{105, -30000, 32000}, '{105, 7, -9});
   endtask

   // polyline kind: single vertex, projections, sentinel vertex
   task automatic test_polyline_kind();
      send_shape(KIND_POLYLINE, 0, 0, 32767, '{0}, '{0});
      send_shape(KIND_POLYLINE, 3, 4, 4, '{-10, 10, 10}, '{0, 0, 20});
      send_shape(KIND_POLYLINE, -7, 9, 5, '{-32767, 32766}, '{-32767, 32766});
      send_shape(KIND_POLYLINE, 0, 1, 2, '{SENT_HI, 0}, '{0, 0});
   endtask

   // polygon kind and its alias: inside, outside near an edge, closing edge
   task automatic test_polygon_kind();
      send_shape(KIND_POLYGON, 5, 5, 0, '{0, 10, 10, 0}, '{0, 0, 10, 10});
      send_shape(KIND_POLYGON, 12, 5, 2, '{0, 10, 10, 0}, '{0, 0, 10, 10});
      send_shape(KIND_POLYGON, -1, 5, 1, '{0, 10, 10, 0}, '{0, 0, 10, 10});
      send_shape(KIND_POLYGON, 3, 3, 1, '{3}, '{4});
      send_shape(KIND_ALIAS, 1, 1, 0, '{-32768, 32767, 0}, '{-32768, -32768, 32767});
      send_shape(KIND_ALIAS, 40, 40, 3, '{0, 20}, '{0, 20});
   endtask

   function automatic longint clip16(longint c);
      if (c > SENT_HI) return SENT_HI;
      if (c < SENT_LO) return SENT_LO;
      return c;
   endfunction

   function automatic longint any_coord();
      return longint'($signed(16'($urandom)));
   endfunction

   // random shapes: mostly compact shapes around the query, some full-range noise
   task automatic test_random_shapes();
      int sent;
      int count;
      logic [1:0] kind;
      longint cx, cy, span, qx, qy, rad, vx, vy;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         kind = 2'($urandom_range(0, 3));
         count = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 7);
         cx = any_coord();
         cy = any_coord();
         span = 1 << $urandom_range(2, 15);
         if ($urandom_range(9) == 0) begin
            qx = any_coord(); qy = any_coord();
         end else begin
            qx = clip16(cx + $signed($urandom_range(0, 2 * span)) - span);
            qy = clip16(cy + $signed($urandom_range(0, 2 * span)) - span);
         end
         rad = ($urandom_range(7) == 0) ? $urandom_range(0, 32767)
                                         : $urandom_range(0, span < 32767 ? span : 32767);
         for (int i = 0; i < count; i++) begin
            if ($urandom_range(19) == 0) begin
               vx = $urandom_range(1) ? SENT_HI : SENT_LO;
               vy = any_coord();
            end else if ($urandom_range(11) == 0) begin
               vx = any_coord(); vy = any_coord();
            end else begin
               vx = clip16(cx + $signed($urandom_range(0, 2 * span)) - span);
               vy = clip16(cy + $signed($urandom_range(0, 2 * span)) - span);
            end
            // query fields after the first vertex are ignored, so scramble them
            if (i == 0)
               send_vertex(kind, qx, qy, rad, vx, vy, count == 1);
            else
               send_vertex(2'($urandom), any_coord(), any_coord(), $urandom_range(0, 32767),
                           vx, vy, i == count - 1);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      int wait_cycles;
      reset            <= 1;
      req_valid        <= 0;
      req_kind         <= KIND_POINT;
      req_query_x      <= 0;
      req_query_y      <= 0;
      req_radius       <= 0;
      req_vertex_x     <= 0;
      req_vertex_y     <= 0;
      req_final_vertex <= 0;
      rsp_ready        <= 0;
      clear_shape();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      test_point_kind();
      test_polyline_kind();
      test_polygon_kind();
      test_random_shapes();
      req_valid <= 0;

      // drain outstanding results, then let the block settle
      wait_cycles = 0;
      while (pending_verdicts.size() != 0 && wait_cycles < STALL_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_verdicts.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/shpx_pkg.sv
rtl/shpx_dp.sv
rtl/shpx_ctrl.sv
rtl/shape_proximity_hit_test_top.sv
rtl/shpx_checker.sv
bench/tb.sv
